// ===== sv/voxel_box_fill_and_count_macros.svh =====
// Assertion macros shared by the voxel box fill RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef VOXEL_BOX_FILL_AND_COUNT_MACROS_SVH
`define VOXEL_BOX_FILL_AND_COUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VBF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vbf_pkg.sv =====
// Shared types and constants for the voxel box fill block.
// No dependencies; imported by every module of the block.
package vbf_pkg;

    localparam int COORD_W    = 18;
    localparam int COUNT_W    = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 112;   // six 18-bit bounds, padded to bytes
    localparam int OUT_DATA_W = 24;    // 22-bit count, padded to bytes
    localparam int AXES       = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord WIN_LOW_RST  = -18'sd50;
    localparam t_coord WIN_HIGH_RST = 18'sd50;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH = 3'd5;

    typedef struct packed {
        logic skip;    // cuboid reaches outside the usable window
        logic empty;   // min above max on some axis
    } t_plan;

    typedef struct packed {
        logic rd;      // read a row for read-modify-write
        logic clr;     // write a zero row (reset sweep)
        logic on;      // set (1) or clear (0) the masked cells
    } t_rmw_ctl;

endpackage

// ===== sv/voxel_box_fill_and_count.sv =====
// Voxel box fill: a SIDE^3 bitmap over a configurable window, one bit per
// cell, held as SIDE*SIDE rows of SIDE bits in a single-port-write memory.
// After reset the block sweeps the memory to zero, one row per cycle, and
// takes no cuboid until done; window writes are taken at any time. A cuboid
// that lies inside the window updates one row per cycle with a
// read-modify-write through the memory port, walking its ny*nz rows (ny, nz:
// its extent on y and z, up to SIDE*SIDE rows); an ignored or empty cuboid
// updates no rows. The next cuboid is taken only once the last one's row
// updates have drained and its result has entered the output register.
// One result is returned per cuboid: the saturated count of set cells and
// an ignored flag. The result waits in an output register so the next
// cuboid can be taken while it is still pending.
// Depends on vbf_pkg, vbf_window, vbf_row_mem, vbf_popcount and the macros.
`include "voxel_box_fill_and_count_macros.svh"
module voxel_box_fill_and_count import vbf_pkg::*; #(
    parameter int SIDE = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_W-1:0]    i_cfg_wdata,
    // input cuboids
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: box_x_min, box_x_max, box_y_min, box_y_max,
    // box_z_min, box_z_max (18 bits each), 4 zero bits
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,   // turn_on
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // lit_count (22 bits), 2 zero bits
    output logic                  m_axis_tuser    // ignored
);

    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(SIDE);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PLAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RUN    = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]         r_state, n_state;
    t_coord             r_wlo  [AXES];
    t_coord             r_whi  [AXES];
    t_coord             r_bmin [AXES];
    t_coord             r_bmax [AXES];
    logic               r_on;
    logic [AW-1:0]      r_clr_addr;
    logic [OW-1:0]      r_oy, r_oz;
    logic [SIDE-1:0]    r_mask, n_mask;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_ign;

    t_plan              w_plan;
    logic [OW-1:0]      w_off_lo [AXES];
    logic [OW-1:0]      w_off_hi [AXES];
    t_rmw_ctl           w_ctl;
    logic [AW-1:0]      w_row_addr;
    logic [AW-1:0]      w_mem_addr;
    logic [SIDE-1:0]    w_chg;
    logic               w_chg_v;
    logic               w_rmw_busy;
    logic               w_pop_busy;
    logic [COUNT_W-1:0] w_count;
    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_y_last, w_z_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_y_last      = (r_oy == w_off_hi[1]);
    assign w_z_last      = (r_oz == w_off_hi[2]);

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_wlo[a] <= WIN_LOW_RST;
                r_whi[a] <= WIN_HIGH_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_LOW:  r_wlo[0] <= i_cfg_wdata;
                CFG_X_HIGH: r_whi[0] <= i_cfg_wdata;
                CFG_Y_LOW:  r_wlo[1] <= i_cfg_wdata;
                CFG_Y_HIGH: r_whi[1] <= i_cfg_wdata;
                CFG_Z_LOW:  r_wlo[2] <= i_cfg_wdata;
                CFG_Z_HIGH: r_whi[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured cuboid
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_on <= s_axis_tuser;
            for (int a = 0; a < AXES; a++) begin
                r_bmin[a] <= s_axis_tdata[a*2*COORD_W +: COORD_W];
                r_bmax[a] <= s_axis_tdata[(a*2+1)*COORD_W +: COORD_W];
            end
        end
    end

    vbf_window #(.SIDE(SIDE)) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (r_state == S_PLAN),
        .i_win_lo  (r_wlo),
        .i_win_hi  (r_whi),
        .i_box_min (r_bmin),
        .i_box_max (r_bmax),
        .o_plan    (w_plan),
        .o_off_lo  (w_off_lo),
        .o_off_hi  (w_off_hi)
    );

    always_comb begin
        for (int i = 0; i < SIDE; i++) begin
            n_mask[i] = (i >= int'(w_off_lo[0])) && (i <= int'(w_off_hi[0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_mask <= n_mask;
        end
    end

    assign w_row_addr = AW'(r_oz) * AW'(SIDE) + AW'(r_oy);
    assign w_mem_addr = (r_state == S_CLEAR) ? r_clr_addr : w_row_addr;

    always_comb begin
        w_ctl     = '0;
        w_ctl.rd  = (r_state == S_RUN);
        w_ctl.clr = (r_state == S_CLEAR);
        w_ctl.on  = r_on;
    end

    vbf_row_mem #(.SIDE(SIDE)) u_row_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_addr  (w_mem_addr),
        .i_mask  (r_mask),
        .o_chg   (w_chg),
        .o_chg_v (w_chg_v),
        .o_busy  (w_rmw_busy)
    );

    vbf_popcount #(.SIDE(SIDE)) u_popcount (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chg   (w_chg),
        .i_chg_v (w_chg_v),
        .i_on    (r_on),
        .o_count (w_count),
        .o_busy  (w_pop_busy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (w_plan.skip || w_plan.empty) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_y_last && w_z_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_rmw_busy && !w_pop_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // row walk: y inner, z outer
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_oy <= w_off_lo[1];
            r_oz <= w_off_lo[2];
        end else if (r_state == S_RUN) begin
            if (w_y_last) begin
                r_oy <= w_off_lo[1];
                r_oz <= r_oz + OW'(1);
            end else begin
                r_oy <= r_oy + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_count <= w_count;
            r_out_ign   <= w_plan.skip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_count);
    assign m_axis_tuser  = r_out_ign;

    `VBF_ASSERT_IMPL(a_done_drained, i_clk, i_rst_n, r_state == S_DONE,
        !w_rmw_busy && !w_pop_busy, "result taken while row updates in flight")
    `VBF_ASSERT_IMPL(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR,
        !w_rmw_busy, "row update in flight during clearing sweep")
    `VBF_ASSERT_IMPL(a_row_in_range, i_clk, i_rst_n, r_state == S_RUN,
        r_oy >= w_off_lo[1] && r_oy <= w_off_hi[1] && r_oz >= w_off_lo[2] && r_oz <= w_off_hi[2],
        "row walk left the cuboid")
    `VBF_ASSERT_NEXT(a_accept_plans, i_clk, i_rst_n, w_in_xfer,
        r_state == S_PLAN, "accepted cuboid not taken to window test")

endmodule

// ===== sv/vbf_window.sv =====
// Window test and offset computation for one cuboid.
// Depends on vbf_pkg; results are registered when i_en is high.
module vbf_window import vbf_pkg::*; #(
    parameter int SIDE = 128,
    localparam int OW = $clog2(SIDE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_coord        i_win_lo  [AXES],
    input  t_coord        i_win_hi  [AXES],
    input  t_coord        i_box_min [AXES],
    input  t_coord        i_box_max [AXES],
    output t_plan         o_plan,
    output logic [OW-1:0] o_off_lo  [AXES],
    output logic [OW-1:0] o_off_hi  [AXES]
);

    logic signed [COORD_W:0] w_lo   [AXES];
    logic signed [COORD_W:0] w_hi   [AXES];
    logic signed [COORD_W:0] w_top  [AXES];
    logic signed [COORD_W:0] w_min  [AXES];
    logic signed [COORD_W:0] w_max  [AXES];
    logic signed [COORD_W:0] w_dlo  [AXES];
    logic signed [COORD_W:0] w_dhi  [AXES];
    t_plan                   n_plan;

    always_comb begin
        n_plan = '0;
        for (int a = 0; a < AXES; a++) begin
            w_lo[a]  = (COORD_W+1)'(i_win_lo[a]);
            w_hi[a]  = (COORD_W+1)'(i_win_hi[a]);
            w_min[a] = (COORD_W+1)'(i_box_min[a]);
            w_max[a] = (COORD_W+1)'(i_box_max[a]);
            // usable high bound is limited to SIDE cells from the low corner
            w_top[a] = w_lo[a] + (COORD_W+1)'(SIDE - 1);
            if (w_hi[a] < w_top[a]) begin
                w_top[a] = w_hi[a];
            end
            if (w_min[a] < w_lo[a] || w_max[a] > w_top[a]) begin
                n_plan.skip = 1'b1;
            end
            if (w_min[a] > w_max[a]) begin
                n_plan.empty = 1'b1;
            end
            w_dlo[a] = w_min[a] - w_lo[a];
            w_dhi[a] = w_max[a] - w_lo[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_plan <= '0;
        end else if (i_en) begin
            o_plan <= n_plan;
        end
    end

    // offsets are only meaningful when the cuboid passes and is not empty
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AXES; a++) begin
                o_off_lo[a] <= w_dlo[a][OW-1:0];
                o_off_hi[a] <= w_dhi[a][OW-1:0];
            end
        end
    end

endmodule

// ===== sv/vbf_row_mem.sv =====
// Bitmap row memory with read-modify-write and the reset clearing sweep.
// Depends on vbf_pkg; emits the changed bits of each updated row.
module vbf_row_mem import vbf_pkg::*; #(
    parameter int SIDE = 128,
    localparam int DEPTH = SIDE * SIDE,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_rmw_ctl        i_ctl,
    input  logic [AW-1:0]   i_addr,
    input  logic [SIDE-1:0] i_mask,
    output logic [SIDE-1:0] o_chg,
    output logic            o_chg_v,
    output logic            o_busy
);

    logic [SIDE-1:0] r_mem [DEPTH];
    logic [SIDE-1:0] r_rd_data;
    logic [AW-1:0]   r_addr;
    logic            r_on;
    logic            r_rd_v;
    logic [SIDE-1:0] n_row;

    always_comb begin
        if (r_on) begin
            n_row = r_rd_data | i_mask;
        end else begin
            n_row = r_rd_data & ~i_mask;
        end
    end

    // one write port: sweep writes and row write-backs never coincide
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_mem[i_addr] <= '0;
        end else if (r_rd_v) begin
            r_mem[r_addr] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_addr];
            r_addr    <= i_addr;
            r_on      <= i_ctl.on;
        end
        o_chg <= r_rd_data ^ n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            o_chg_v <= 1'b0;
        end else begin
            r_rd_v  <= i_ctl.rd;
            o_chg_v <= r_rd_v;
        end
    end

    assign o_busy = r_rd_v | o_chg_v;

endmodule

// ===== sv/vbf_popcount.sv =====
// Registered population count of changed row bits and the running total.
// Depends on vbf_pkg; output count saturates at the 22-bit maximum.
module vbf_popcount import vbf_pkg::*; #(
    parameter int SIDE = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SIDE-1:0]    i_chg,
    input  logic               i_chg_v,
    input  logic               i_on,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_busy
);

    localparam int NGRP  = (SIDE + 7) / 8;
    localparam int NPART = (NGRP + 3) / 4;
    localparam int PW    = NGRP * 8;
    localparam int DW    = $clog2(SIDE + 1);
    localparam int TW    = $clog2(SIDE * SIDE * SIDE + 1);
    localparam int SW    = (TW > COUNT_W) ? TW : COUNT_W;

    logic [PW-1:0]    w_pad;
    logic [3:0]       n_grp  [NGRP];
    logic [3:0]       r_grp  [NGRP];
    logic [DW-1:0]    n_part [NPART];
    logic [DW-1:0]    r_part [NPART];
    logic [DW-1:0]    n_delta;
    logic [DW-1:0]    r_delta;
    logic             r_v1, r_v2, r_v3;
    logic [TW-1:0]    r_total;
    logic [SW-1:0]    w_total_ext;

    assign w_pad = PW'(i_chg);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                n_grp[g] = n_grp[g] + 4'(w_pad[g*8 + b]);
            end
        end
        for (int k = 0; k < NPART; k++) begin
            n_part[k] = '0;
            for (int j = 0; j < 4; j++) begin
                if (k*4 + j < NGRP) begin
                    n_part[k] = n_part[k] + DW'(r_grp[k*4 + j]);
                end
            end
        end
        n_delta = '0;
        for (int k = 0; k < NPART; k++) begin
            n_delta = n_delta + r_part[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp   <= n_grp;
        r_part  <= n_part;
        r_delta <= n_delta;
    end

    // every change within one cuboid goes the same way
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_total <= '0;
        end else begin
            r_v1 <= i_chg_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                if (i_on) begin
                    r_total <= r_total + TW'(r_delta);
                end else begin
                    r_total <= r_total - TW'(r_delta);
                end
            end
        end
    end

    assign w_total_ext = SW'(r_total);
    assign o_count = (w_total_ext > SW'(COUNT_MAX)) ? COUNT_MAX : w_total_ext[COUNT_W-1:0];
    assign o_busy  = r_v1 | r_v2 | r_v3;

endmodule
